>>> src/http_request_completion_check_core_assert.svh
// Assertion macros for the request completion checker.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef HTTP_REQUEST_COMPLETION_CHECK_CORE_ASSERT_SVH
`define HTTP_REQUEST_COMPLETION_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define HRCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HRCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HRCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HRCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/hrcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrcc_pkg;

  // Default sizes of the byte counter and the length value
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned LENGTH_BITS_DEF = 32;

  // Fixed field width of the header size
  localparam int unsigned HDR_BITS = 16;

  // Records held between the scanner and the verdict stage
  localparam int unsigned QUEUE_DEPTH = 2;

  // Framing found in the header window; chunked wins over length, length over boundary
  typedef enum logic [1:0] {
    FRAME_NONE     = 2'd0,
    FRAME_CHUNKED  = 2'd1,
    FRAME_LENGTH   = 2'd2,
    FRAME_BOUNDARY = 2'd3
  } frame_e;

  // Progress of the length value parser
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic [HDR_BITS-1:0] header_bytes;
    logic                last_byte;
  } req_t;

  typedef struct packed {
    logic       request_done;
    logic [1:0] framing_kind;
    logic       header_ended;
  } res_t;

  // Classification of one finished request
  typedef struct packed {
    frame_e kind;
    logic   header_ended;
    logic   body_term;
    logic   colon_seen;
    logic   negative;
  } flags_t;

endpackage

`default_nettype wire

>>> src/http_request_completion_check_core.sv
// HTTP request completion checker.
// Input channel: a queue-style push port. Each transfer carries one request
// byte, the header size for that request and a flag marking the final byte.
// A byte is taken on a clock edge with push high and full low; one byte can
// be taken every cycle, back to back, with no gaps between requests.
// Result channel: a queue-style pop port. Only the final byte of a request
// yields a result (done flag, framing kind, header-ended flag); it is on
// res_o while empty is low and leaves on an edge with pop high.
// A final byte's record enters the record queue on the edge that takes the
// byte and moves on into the result register once that is free or taken.
// Throughput is one byte per cycle while full is low, set by the byte scanner.
// When the receiver stalls, results collect in a two-entry record queue and
// the result register; full rises only once all three hold a result, and
// bytes of a request still in progress keep flowing until then.
// Reset clears all scan state and empties the queue; each final byte also
// clears the scan state so the next byte starts a new request.
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_completion_check_core_assert.svh"

module http_request_completion_check_core import hrcc_pkg::*; #(
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire req_t req_i,
  output logic      empty,
  input  wire logic pop,
  output res_t      res_o
);

  logic                   accept;
  logic                   rec_valid;
  flags_t                 rec_flags;
  logic [COUNT_BITS-1:0]  rec_count;
  logic [HDR_BITS-1:0]    rec_hdr;
  logic [LENGTH_BITS-1:0] rec_mag;

  assign accept = push && !full;

  // Scan bytes and classify each request
  hrcc_front #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .rec_valid_o (rec_valid),
    .rec_flags_o (rec_flags),
    .rec_count_o (rec_count),
    .rec_hdr_o   (rec_hdr),
    .rec_mag_o   (rec_mag)
  );

  // Queue records and produce verdicts
  hrcc_back #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_flags_i (rec_flags),
    .rec_count_i (rec_count),
    .rec_hdr_i   (rec_hdr),
    .rec_mag_i   (rec_mag),
    .full_o      (full),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

  // A record leaves the scanner exactly for a taken final byte
  `HRCC_ASSERT_IMP(a_rec_on_last, clk_i, rst_ni, accept, rec_valid == req_i.last_byte, "record mismatch")
  // A complete request always had its header terminated
  `HRCC_ASSERT_IMP(a_done_hdr, clk_i, rst_ni, !empty && res_o.request_done, res_o.header_ended, "done without header end")
  // A full queue implies a waiting result
  `HRCC_ASSERT_IMP(a_full_out, clk_i, rst_ni, full, !empty, "queue full while result register empty")
  // A full queue stays full until a result is taken
  `HRCC_ASSERT_NXT(a_full_hold, clk_i, rst_ni, full && !pop, full, "full dropped without a pop")

endmodule

`default_nettype wire

>>> src/hrcc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hrcc_front import hrcc_pkg::*; #(
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire req_t                   req_i,
  output logic                        rec_valid_o,
  output flags_t                      rec_flags_o,
  output logic [COUNT_BITS-1:0]       rec_count_o,
  output logic [HDR_BITS-1:0]         rec_hdr_o,
  output logic [LENGTH_BITS-1:0]      rec_mag_o
);

  localparam int unsigned HIST_BYTES = 16;
  localparam int unsigned CMP_W = (COUNT_BITS > HDR_BITS) ? COUNT_BITS : HDR_BITS;
  localparam int unsigned PROD_W = LENGTH_BITS + 4;

  localparam logic [COUNT_BITS-1:0]  CNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] MAG_LIMIT = {1'b1, {(LENGTH_BITS-1){1'b0}}};

  localparam logic [31:0]  TERM_SEQ  = 32'h0d0a_0d0a;
  localparam logic [55:0]  CHUNK_KEY = "chunked";
  localparam logic [111:0] LEN_KEY   = "Content-Length";
  localparam logic [127:0] LEN_COLON = "Content-Length: ";
  localparam logic [71:0]  BOUND_KEY = "boundary=";

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic [HIST_BYTES*8-1:0]  hist_q, hist_d;
  logic                     text_end_q, text_end_d;
  logic                     hdr_end_q, hdr_end_d;
  logic [COUNT_BITS-1:0]    body_start_q, body_start_d;
  logic                     body_term_q, body_term_d;
  logic                     chunk_q, chunk_d;
  logic                     key_q, key_d;
  logic                     colon_q, colon_d;
  logic                     bound_q, bound_d;
  phase_e                   phase_q, phase_d;
  logic [LENGTH_BITS-1:0]   mag_q, mag_d;
  logic                     neg_q, neg_d;

  logic [7:0]               data_b;
  logic [HIST_BYTES*8-1:0]  win;
  logic                     in_window;
  logic                     is_digit;
  logic                     is_ws;
  logic [PROD_W-1:0]        prod;
  logic [LENGTH_BITS-1:0]   mag_add;
  logic [COUNT_BITS+1:0]    term_min;

  assign data_b    = req_i.data_byte;
  assign win       = {hist_q[HIST_BYTES*8-9:0], data_b};
  assign in_window = CMP_W'(count_q) < CMP_W'(req_i.header_bytes);
  assign is_digit  = (data_b >= CH_ZERO) && (data_b <= CH_NINE);
  assign is_ws     = (data_b == CH_SP) || ((data_b >= CH_TAB) && (data_b <= CH_CR));
  assign term_min  = {2'b00, body_start_q} + (COUNT_BITS+2)'(3);

  // Multiply by ten and add the digit, saturating at the magnitude limit
  always_comb begin
    prod    = (PROD_W'(mag_q) << 3) + (PROD_W'(mag_q) << 1) + PROD_W'(data_b[3:0]);
    mag_add = (prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : prod[LENGTH_BITS-1:0];
  end

  // Scan one byte and update matchers, counters and the value parser
  always_comb begin
    count_d      = count_q;
    hist_d       = hist_q;
    text_end_d   = text_end_q;
    hdr_end_d    = hdr_end_q;
    body_start_d = body_start_q;
    body_term_d  = body_term_q;
    chunk_d      = chunk_q;
    key_d        = key_q;
    colon_d      = colon_q;
    bound_d      = bound_q;
    phase_d      = phase_q;
    mag_d        = mag_q;
    neg_d        = neg_q;

    if (accept_i) begin
      if (count_q != CNT_MAX) begin
        count_d = count_q + COUNT_BITS'(1);
      end
      if (!text_end_q) begin
        if (data_b == 8'h00) begin
          text_end_d = 1'b1;
        end else begin
          hist_d = win;

          // Parse the length value text
          case (phase_q)
            PH_SIGN: begin
              if (data_b == CH_LF && hist_q[7:0] == CH_CR) begin
                phase_d = PH_DONE;
              end else if (is_ws) begin
                phase_d = PH_SIGN;
              end else if (data_b == CH_PLUS) begin
                phase_d = PH_DIGIT;
              end else if (data_b == CH_MINUS) begin
                neg_d   = 1'b1;
                phase_d = PH_DIGIT;
              end else if (is_digit) begin
                mag_d   = mag_add;
                phase_d = PH_DIGIT;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_DIGIT: begin
              if (is_digit) begin
                mag_d = mag_add;
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
            end
          endcase

          // Track the first and the second blank-line terminator
          if (win[31:0] == TERM_SEQ) begin
            if (!hdr_end_q) begin
              hdr_end_d    = 1'b1;
              body_start_d = (count_q != CNT_MAX) ? count_q + COUNT_BITS'(1) : CNT_MAX;
            end else if ({2'b00, count_q} >= term_min) begin
              body_term_d = 1'b1;
            end
          end

          // Match keys that end inside the header window
          if (in_window) begin
            if (win[55:0] == CHUNK_KEY) begin
              chunk_d = 1'b1;
            end
            if (win[111:0] == LEN_KEY) begin
              key_d = 1'b1;
            end
            if (win[71:0] == BOUND_KEY) begin
              bound_d = 1'b1;
            end
            if (phase_q == PH_WAIT && win == LEN_COLON) begin
              colon_d = 1'b1;
              phase_d = PH_SIGN;
            end
          end
        end
      end
    end

    // Hand the finished request to the verdict stage
    rec_valid_o              = accept_i && req_i.last_byte;
    rec_flags_o.kind         = chunk_d ? FRAME_CHUNKED :
                               key_d   ? FRAME_LENGTH  :
                               bound_d ? FRAME_BOUNDARY : FRAME_NONE;
    rec_flags_o.header_ended = hdr_end_d;
    rec_flags_o.body_term    = body_term_d;
    rec_flags_o.colon_seen   = colon_d;
    rec_flags_o.negative     = neg_d;
    rec_count_o              = count_d;
    rec_hdr_o                = req_i.header_bytes;
    rec_mag_o                = mag_d;

    // Clear all scan state for the next request
    if (rec_valid_o) begin
      count_d      = '0;
      hist_d       = '0;
      text_end_d   = 1'b0;
      hdr_end_d    = 1'b0;
      body_start_d = '0;
      body_term_d  = 1'b0;
      chunk_d      = 1'b0;
      key_d        = 1'b0;
      colon_d      = 1'b0;
      bound_d      = 1'b0;
      phase_d      = PH_WAIT;
      mag_d        = '0;
      neg_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      hist_q       <= '0;
      text_end_q   <= 1'b0;
      hdr_end_q    <= 1'b0;
      body_start_q <= '0;
      body_term_q  <= 1'b0;
      chunk_q      <= 1'b0;
      key_q        <= 1'b0;
      colon_q      <= 1'b0;
      bound_q      <= 1'b0;
      phase_q      <= PH_WAIT;
      mag_q        <= '0;
      neg_q        <= 1'b0;
    end else begin
      count_q      <= count_d;
      hist_q       <= hist_d;
      text_end_q   <= text_end_d;
      hdr_end_q    <= hdr_end_d;
      body_start_q <= body_start_d;
      body_term_q  <= body_term_d;
      chunk_q      <= chunk_d;
      key_q        <= key_d;
      colon_q      <= colon_d;
      bound_q      <= bound_d;
      phase_q      <= phase_d;
      mag_q        <= mag_d;
      neg_q        <= neg_d;
    end
  end

endmodule

`default_nettype wire

>>> src/hrcc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hrcc_back import hrcc_pkg::*; #(
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   rec_valid_i,
  input  wire flags_t                 rec_flags_i,
  input  wire logic [COUNT_BITS-1:0]  rec_count_i,
  input  wire logic [HDR_BITS-1:0]    rec_hdr_i,
  input  wire logic [LENGTH_BITS-1:0] rec_mag_i,
  output logic                        full_o,
  output logic                        empty_o,
  input  wire logic                   pop_i,
  output res_t                        res_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW_A   = (COUNT_BITS > HDR_BITS) ? COUNT_BITS : HDR_BITS;
  localparam int unsigned CW     = (CW_A > LENGTH_BITS) ? CW_A : LENGTH_BITS;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {1'b0, {(LENGTH_BITS-1){1'b1}}};

  flags_t                  flags_q [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0]   count_q [QUEUE_DEPTH];
  logic [HDR_BITS-1:0]     hdr_q   [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0]  mag_q   [QUEUE_DEPTH];

  logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]        fill_q;
  logic                    out_valid_q;
  res_t                    out_q;

  logic                    move;
  logic                    take;
  flags_t                  head_flags;
  logic [CW-1:0]           cnt_x, hdr_x, mag_x, pos_x, diff;
  logic                    ge;
  logic                    mag_zero;
  logic                    len_ok;
  logic                    done;

  assign full_o  = fill_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = !out_valid_q;
  assign res_o   = out_q;
  assign take    = pop_i && out_valid_q;
  assign move    = (fill_q != '0) && (!out_valid_q || pop_i);

  // Work out the verdict for the oldest queued request
  always_comb begin
    head_flags = flags_q[rd_ptr_q];
    cnt_x      = CW'(count_q[rd_ptr_q]);
    hdr_x      = CW'(hdr_q[rd_ptr_q]);
    mag_x      = CW'(mag_q[rd_ptr_q]);
    pos_x      = mag_q[rd_ptr_q][LENGTH_BITS-1] ? CW'(POS_MAX) : mag_x;
    mag_zero   = mag_q[rd_ptr_q] == '0;
    ge         = cnt_x >= hdr_x;
    diff       = ge ? cnt_x - hdr_x : hdr_x - cnt_x;

    // Body shorter than zero wraps to a huge length
    if (ge) begin
      len_ok = head_flags.negative ? mag_zero : (pos_x <= diff);
    end else begin
      len_ok = head_flags.negative ? (mag_zero || mag_x >= diff) : 1'b1;
    end

    if (!head_flags.header_ended) begin
      done = 1'b0;
    end else begin
      case (head_flags.kind)
        FRAME_CHUNKED:  done = head_flags.body_term;
        FRAME_BOUNDARY: done = head_flags.body_term;
        FRAME_LENGTH:   done = head_flags.colon_seen && len_ok;
        default:        done = 1'b1;
      endcase
    end
  end

  // Store incoming records
  always_ff @(posedge clk_i) begin
    if (rec_valid_i) begin
      flags_q[wr_ptr_q] <= rec_flags_i;
      count_q[wr_ptr_q] <= rec_count_i;
      hdr_q[wr_ptr_q]   <= rec_hdr_i;
      mag_q[wr_ptr_q]   <= rec_mag_i;
    end
  end

  // Load the result register when it is free or being taken
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.request_done <= done;
      out_q.framing_kind <= head_flags.kind;
      out_q.header_ended <= head_flags.header_ended;
    end
  end

  // Advance pointers, fill level and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rec_valid_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (move) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      fill_q      <= fill_q + CNT_W'(rec_valid_i) - CNT_W'(move);
      out_valid_q <= move || (out_valid_q && !take);
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import hrcc_pkg::*;

  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam logic [63:0] MAG_CAP   = 64'd1 << (LENGTH_BITS_DEF - 1);

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  req_t req    = '0;
  logic full;
  logic empty;
  res_t res;

  http_request_completion_check_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting to be offered, verdicts waiting to arrive
  req_t       send_q[$];
  res_t       verdict_q[$];
  logic [7:0] msg_q[$];

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int sent_bytes    = 0;
  int sent_msgs     = 0;
  int mismatches    = 0;
  bit stall_go      = 1'b0;

  // Scanner state of the request in progress
  logic [63:0] seen_cnt;
  logic [7:0]  tail_buf[16];
  bit          stopped;
  bit          hdr_done;
  bit          body_done;
  bit          saw_chunked;
  bit          saw_key;
  bit          saw_colon;
  bit          saw_boundary;
  phase_e      val_phase;
  logic [63:0] val_mag;
  bit          val_neg;
  logic [63:0] body_at;

  function automatic void clear_scan();
    seen_cnt     = '0;
    tail_buf     = '{default: 8'h00};
    stopped      = 1'b0;
    hdr_done     = 1'b0;
    body_done    = 1'b0;
    saw_chunked  = 1'b0;
    saw_key      = 1'b0;
    saw_colon    = 1'b0;
    saw_boundary = 1'b0;
    val_phase    = PH_WAIT;
    val_mag      = '0;
    val_neg      = 1'b0;
    body_at      = '0;
  endfunction

  function automatic bit tail_has(string pat);
    int n = pat.len();
    for (int k = 0; k < n; k++) begin
      if (tail_buf[16 - n + k] != pat[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Accumulate one decimal digit, saturating the magnitude
  function automatic void add_digit(logic [7:0] c);
    val_mag = val_mag * 64'd10 + 64'(c - "0");
    if (val_mag > MAG_CAP) val_mag = MAG_CAP;
  endfunction

  // Advance the scanner by one byte; on the final byte queue the verdict
  function automatic void scan_byte(req_t it);
    logic [7:0]  b   = it.data_byte;
    logic [63:0] hdr = 64'(it.header_bytes);
    logic [63:0] idx = seen_cnt;
    logic [63:0] lim;
    logic [63:0] room;
    frame_e      fk;
    res_t        r;
    if (seen_cnt < COUNT_TOP) seen_cnt++;
    if (!stopped) begin
      if (b == 8'h00) begin
        stopped = 1'b1;
      end else begin
        for (int k = 0; k < 15; k++) tail_buf[k] = tail_buf[k + 1];
        tail_buf[15] = b;
        // length value, parsed as atoi would
        if (val_phase == PH_SIGN) begin
          if (b == "\n" && tail_buf[14] == "\r") val_phase = PH_DONE;
          else if (b == " " || (b >= 8'd9 && b <= 8'd13)) val_phase = PH_SIGN;
          else if (b == "+") val_phase = PH_DIGIT;
          else if (b == "-") begin
            val_neg   = 1'b1;
            val_phase = PH_DIGIT;
          end else if (b >= "0" && b <= "9") begin
            add_digit(b);
            val_phase = PH_DIGIT;
          end else val_phase = PH_DONE;
        end else if (val_phase == PH_DIGIT) begin
          if (b >= "0" && b <= "9") add_digit(b);
          else val_phase = PH_DONE;
        end
        // header terminator, then a second one inside the body
        if (tail_has("\r\n\r\n")) begin
          if (!hdr_done) begin
            hdr_done = 1'b1;
            body_at  = (idx < COUNT_TOP) ? idx + 64'd1 : COUNT_TOP;
          end else if (idx >= 64'd3 && idx - 64'd3 >= body_at) begin
            body_done = 1'b1;
          end
        end
        // keys count only inside the header window
        if (idx < hdr) begin
          if (tail_has("chunked")) saw_chunked = 1'b1;
          if (tail_has("Content-Length")) saw_key = 1'b1;
          if (tail_has("boundary=")) saw_boundary = 1'b1;
          if (val_phase == PH_WAIT && tail_has("Content-Length: ")) begin
            saw_colon = 1'b1;
            val_phase = PH_SIGN;
          end
        end
      end
    end
    if (it.last_byte) begin
      fk = saw_chunked ? FRAME_CHUNKED : saw_key ? FRAME_LENGTH :
           saw_boundary ? FRAME_BOUNDARY : FRAME_NONE;
      r.framing_kind = fk;
      r.header_ended = hdr_done;
      if (!hdr_done) r.request_done = 1'b0;
      else if (fk == FRAME_CHUNKED || fk == FRAME_BOUNDARY) r.request_done = body_done;
      else if (fk == FRAME_LENGTH) begin
        if (!saw_colon) r.request_done = 1'b0;
        else begin
          room = seen_cnt - hdr;
          lim  = val_neg ? 64'd0 - val_mag :
                 (val_mag > MAG_CAP - 64'd1) ? MAG_CAP - 64'd1 : val_mag;
          r.request_done = (lim <= room);
        end
      end else r.request_done = 1'b1;
      verdict_q.push_back(r);
      clear_scan();
    end
  endfunction

  // Offer the oldest pending byte, idling at random
  always @(negedge clk_i) begin
    if (rst_ni && send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      req  <= send_q[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Take results, stalling at random; hold off for one long stretch on request
  int stall_left = 0;
  bit stall_used = 1'b0;
  always @(negedge clk_i) begin
    if (stall_go && !stall_used) begin
      stall_left = 300;
      stall_used = 1'b1;
    end
    if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Check each result transfer, then predict from each byte transfer
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result transfer: %p", res);
        mismatches++;
      end else begin
        exp_r = verdict_q.pop_front();
        if (res.request_done !== exp_r.request_done) begin
          $error("request_done: expected %0d, actual %0d", exp_r.request_done,
                 res.request_done);
          mismatches++;
        end
        if (res.framing_kind !== exp_r.framing_kind) begin
          $error("framing_kind: expected %0d, actual %0d", exp_r.framing_kind,
                 res.framing_kind);
          mismatches++;
        end
        if (res.header_ended !== exp_r.header_ended) begin
          $error("header_ended: expected %0d, actual %0d", exp_r.header_ended,
                 res.header_ended);
          mismatches++;
        end
      end
    end
    if (rst_ni && push && !full) begin
      scan_byte(req);
      void'(send_q.pop_front());
    end
  end

  task automatic load_text(string s);
    for (int k = 0; k < s.len(); k++) msg_q.push_back(s[k]);
  endtask

  // Turn the assembled message into byte transfers, the final one marked last
  task automatic send_msg(int hdr, bit wobble);
    req_t it;
    for (int k = 0; k < msg_q.size(); k++) begin
      it.data_byte    = msg_q[k];
      it.header_bytes = wobble ? 16'($urandom_range(msg_q.size())) : 16'(hdr);
      it.last_byte    = (k == msg_q.size() - 1);
      send_q.push_back(it);
    end
    sent_bytes += msg_q.size();
    sent_msgs++;
    msg_q.delete();
  endtask

  // Header text, then body text; the window is the header length plus an offset
  task automatic send_case(string head, string body, int hdr_adj);
    int hdr;
    load_text(head);
    hdr = msg_q.size() + hdr_adj;
    if (hdr < 0) hdr = 0;
    if (hdr > 65535) hdr = 65535;
    load_text(body);
    send_msg(hdr, 1'b0);
  endtask

  task automatic send_noise(int max_len);
    repeat ($urandom_range(max_len, 1)) msg_q.push_back(8'($urandom_range(255)));
    send_msg($urandom_range(65535), 1'b0);
  endtask

  // Mostly well-formed request with random framing headers and body
  task automatic send_random_request();
    int    body_len;
    int    hdr;
    int    cut;
    string val;
    body_len = $urandom_range(12);
    load_text($urandom_range(1) ? "GET /\r\n" : "POST /u HTTP/1.1\r\n");
    if ($urandom_range(3) == 0) load_text("Transfer-Encoding: chunked\r\n");
    if ($urandom_range(1)) begin
      case ($urandom_range(7))
        0, 1:    val = $sformatf(": %0d\r\n", body_len + int'($urandom_range(2)) - 1);
        2:       val = $sformatf(": \t %0d\r\n", body_len);
        3:       val = $sformatf(": %s%0d\r\n", $urandom_range(1) ? "+" : "-",
                                 $urandom_range(20));
        4:       val = $urandom_range(1) ? ": 99999999999\r\n" : ": -2147483649\r\n";
        5:       val = $sformatf(" %0d\r\n", body_len);
        6:       val = ": \r\n";
        default: val = $sformatf(": %0dq\r\n", body_len);
      endcase
      load_text({"Content-Length", val});
    end
    if ($urandom_range(3) == 0) load_text("Content-Type: multipart/form-data; boundary=b\r\n");
    if ($urandom_range(2) == 0) load_text("X-Pad: z\r\n");
    if ($urandom_range(9) != 0) load_text("\r\n");
    hdr = msg_q.size();
    case ($urandom_range(9))
      0:       hdr = $urandom_range(hdr);
      1:       hdr = hdr + $urandom_range(8);
      2:       hdr = $urandom_range(65535);
      default: ;
    endcase
    for (int k = 0; k < body_len; k++) begin
      case ($urandom_range(7))
        0:       msg_q.push_back("\r");
        1:       msg_q.push_back("\n");
        default: msg_q.push_back(8'($urandom_range(126, 32)));
      endcase
    end
    if ($urandom_range(2) == 0) load_text("\r\n\r\n");
    if ($urandom_range(19) == 0) msg_q.insert($urandom_range(msg_q.size() - 1), 8'h00);
    if ($urandom_range(9) == 0 && msg_q.size() > 1) begin
      cut = $urandom_range(msg_q.size() - 1, 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
    send_msg(hdr, $urandom_range(24) == 0);
  endtask

  task automatic run_random_phase();
    int b0 = sent_bytes;
    int m0 = sent_msgs;
    while (sent_bytes - b0 < 40 || sent_msgs - m0 < 3) begin
      if ($urandom_range(9) < 7) send_random_request();
      else send_noise(8);
    end
  endtask

  // Hold the sender until every queued byte and verdict has gone
  task automatic wait_drained();
    while (send_q.size() != 0 || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clear_scan();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: framing kinds, value forms, window edges, zero byte
    send_idle_pct = 33;
    take_idle_pct = 65;
    send_case("GET /\r\n\r\n", "", 0);
    send_case("GET /\r\n", "", 0);
    send_case("POST /\r\nTransfer-Encoding: chunked\r\n\r\n", "4\r\nabcd\r\n0\r\n\r\n", 0);
    send_case("POST /\r\nContent-Length: 5\r\n\r\n", "hello", 0);
    send_case("POST /\r\nContent-Length:  \t+3\r\n\r\n", "abc", 0);
    send_case("POST /\r\nContent-Length: -7\r\n\r\n", "", 0);
    send_case("POST /\r\nContent-Length: 99999999999\r\n\r\n", "x", 0);
    send_case("POST /\r\nContent-Length: -99999999999\r\n\r\n", "x", 0);
    send_case("POST /\r\nContent-Length 3\r\n\r\n", "abc", 0);
    send_case("POST /\r\nContent-Length: \r\n\r\n", "", 0);
    send_case("POST /\r\nContent-Length: 12ab\r\n\r\n", "", 0);
    send_case("POST /\r\nContent-Type: x; boundary=q\r\n\r\n", "--q\r\n\r\n", 0);
    send_case("POST /\r\nContent-Length: 1\r\nTransfer-Encoding: chunked\r\n\r\n", "x", 0);
    send_case("POST /\r\nContent-Length: 5\r\n\r\n", "hello", -6);
    send_case("POST /\r\nContent-Length: 0\r\n\r\n", "", 70000);
    load_text("GET /\r\n");
    msg_q.push_back(8'h00);
    load_text("\r\n\r\n");
    send_msg(11, 1'b0);
    load_text("POST /\r\nContent-Length: 3\r\n\r\nabc");
    send_msg(0, 1'b1);
    msg_q.push_back(8'hFF);
    send_msg(65535, 1'b0);
    msg_q.push_back(8'h00);
    send_msg(0, 1'b0);
    wait_drained();

    // Random requests under both idling patterns
    send_idle_pct = 33;
    take_idle_pct = 65;
    run_random_phase();
    wait_drained();
    send_idle_pct = 65;
    take_idle_pct = 33;
    run_random_phase();
    wait_drained();

    // Back-pressure: short requests while the receiver holds off
    send_idle_pct = 0;
    take_idle_pct = 0;
    repeat (40) send_noise(2);
    stall_go = 1'b1;
    wait_drained();

    run_random_phase();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/hrcc_pkg.sv
src/hrcc_front.sv
src/hrcc_back.sv
src/http_request_completion_check_core.sv
test/tb.sv
